### hdl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types, codes and defaults of the reference-counted page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 32768;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam int unsigned BASE_W   = 20;
  localparam int unsigned PAGES_W  = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_FREE   = 2'd1,
    FN_ADDREF = 2'd2,
    FN_READ   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ADDR    = 3'd1,
    ST_NO_MEM      = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 1'b0,
    CFG_PAGES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    func_e             func;
    logic [ADDR_W-1:0] page_address;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  granted_address;
    logic [COUNT_W-1:0] ref_count;
  } rsp_t;

  typedef struct packed {
    logic clr_en;
    logic capture;
    logic look_en;
    logic exec_en;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### hdl/rpa_stream_if.sv
// ----------------------------------------------------------------------------
// rpa_stream_if
// Valid/ready channel that carries one word of a given payload type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/refcounted_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit
// Page allocator with a LIFO of freed pages and an 8-bit count per page.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// req_i     in   func, page_address
// rsp_o     out  status, granted_address, ref_count
// cfg_*     in   region_base_page (index 0), region_pages (index 1)
//
// Each word passes through a lookup cycle that reads the count and stack
// memories, then an execute cycle that writes them back and loads the result
// register. The next word is taken in the execute cycle of the previous one.
// After reset a clearing pass zeroes every entry of the count memory,
// during which no request is taken; configuration writes are always taken.
// A result held in the output register stalls the execute cycle.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_page_allocator_unit #(
  parameter int unsigned MAX_PAGES  = rpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rpa_pkg::BASE_W-1:0]    cfg_wdata_i,
  rpa_stream_if.sink                         req_i,
  rpa_stream_if.source                       rsp_o
);

  rpa_pkg::cmd_t  cmd;
  rpa_pkg::stat_t stat;

  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rpa_datapath #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_data_i  (req_i.data),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_data_o  (rsp_o.data)
  );

endmodule

`default_nettype wire

### hdl/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer of the allocator: clearing pass, capture, lookup and execute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire rpa_pkg::stat_t stat_i,
  output rpa_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   exec_fire;

  assign exec_fire   = (state_q == S_EXEC) && stat_i.out_free;
  assign req_ready_o = (state_q == S_IDLE) || exec_fire;

  always_comb begin
    cmd_o.clr_en  = (state_q == S_CLEAR);
    cmd_o.capture = req_valid_i && req_ready_o;
    cmd_o.look_en = (state_q == S_LOOK);
    cmd_o.exec_en = exec_fire;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_free) state_d = req_valid_i ? S_LOOK : S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/rpa_datapath.sv
// ----------------------------------------------------------------------------
// rpa_datapath
// Region registers, address check, count and stack memories, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpa_datapath #(
  parameter int unsigned MAX_PAGES  = rpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rpa_pkg::cmd_t                   cmd_i,
  output rpa_pkg::stat_t                       stat_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rpa_pkg::BASE_W-1:0]      cfg_wdata_i,
  input  wire rpa_pkg::req_t                   req_data_i,
  input  wire logic                            rsp_ready_i,
  output logic                                 rsp_valid_o,
  output rpa_pkg::rsp_t                        rsp_data_o
);

  localparam int unsigned IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PAGES + 1);
  localparam int unsigned PN_W  = rpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int unsigned D_W   = ((PN_W > rpa_pkg::BASE_W) ? PN_W : rpa_pkg::BASE_W) + 1;
  localparam int unsigned C_W   = (D_W > CNT_W) ? D_W : CNT_W;
  localparam int unsigned L_W   = (CNT_W > rpa_pkg::PAGES_W) ? CNT_W : rpa_pkg::PAGES_W;
  localparam int unsigned G_W   = rpa_pkg::BASE_W + 1;
  localparam int unsigned CW    = rpa_pkg::COUNT_W;

  logic [rpa_pkg::BASE_W-1:0]  base_q;
  logic [rpa_pkg::PAGES_W-1:0] pages_q;

  rpa_pkg::func_e              func_q;
  logic [rpa_pkg::ADDR_W-1:0]  addr_q;

  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic [IDX_W-1:0] clr_q;

  logic [IDX_W-1:0] idx_q;
  logic             addr_ok_q;
  logic             stack_hit_q;
  logic             fresh_ok_q;
  logic [CW-1:0]    cnt_rd_q;
  logic [IDX_W-1:0] stk_rd_q;

  logic [CW-1:0]    cnt_mem [MAX_PAGES];
  logic [IDX_W-1:0] stk_mem [MAX_PAGES];

  logic             rsp_valid_q;
  rpa_pkg::rsp_t    rsp_q, rsp_d;

  logic [CNT_W-1:0] live;
  logic [D_W-1:0]   diff;
  logic             in_range;
  logic             aligned;
  logic [IDX_W-1:0] addr_idx;
  logic [CNT_W-1:0] fresh_calc;
  logic [CNT_W-1:0] fill_dec;

  logic             cnt_we;
  logic [IDX_W-1:0] cnt_wa;
  logic [CW-1:0]    cnt_wd;
  logic             stk_we;
  logic [IDX_W-1:0] ex_idx;
  logic [CW-1:0]    cnt_dec;
  logic [G_W-1:0]   gsum;

  // Region registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pages_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rpa_pkg::CFG_BASE) begin
        base_q <= cfg_wdata_i;
      end else begin
        pages_q <= cfg_wdata_i[rpa_pkg::PAGES_W-1:0];
      end
    end
  end

  assign live = (L_W'(pages_q) > L_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : CNT_W'(pages_q);

  // Lookup stage: address check and fresh page selection.
  assign aligned    = (addr_q[PAGE_SHIFT-1:0] == '0);
  assign diff       = D_W'(addr_q[rpa_pkg::ADDR_W-1:PAGE_SHIFT]) - D_W'(base_q);
  assign in_range   = !diff[D_W-1] && (C_W'(diff) < C_W'(live));
  assign addr_idx   = diff[IDX_W-1:0];
  assign fresh_calc = live - fresh_q - CNT_W'(1);
  assign fill_dec   = fill_q - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= req_data_i.func;
      addr_q <= req_data_i.page_address;
    end
    if (cmd_i.look_en) begin
      addr_ok_q   <= aligned && in_range;
      stack_hit_q <= (fill_q != '0);
      fresh_ok_q  <= (fresh_q < live);
      idx_q       <= (func_q == rpa_pkg::FN_ALLOC) ? fresh_calc[IDX_W-1:0] : addr_idx;
    end
  end

  // Execute stage.
  assign cnt_dec = cnt_rd_q - CW'(1);

  always_comb begin
    rsp_d                 = '0;
    rsp_d.status          = rpa_pkg::ST_OK;
    cnt_we                = 1'b0;
    cnt_wd                = '0;
    stk_we                = 1'b0;
    ex_idx                = idx_q;
    fill_d                = fill_q;
    fresh_d               = fresh_q;
    unique case (func_q)
      rpa_pkg::FN_ALLOC: begin
        if (stack_hit_q) begin
          ex_idx = stk_rd_q;
          fill_d = fill_dec;
        end else if (fresh_ok_q) begin
          fresh_d = fresh_q + CNT_W'(1);
        end
        if (stack_hit_q || fresh_ok_q) begin
          cnt_we          = 1'b1;
          cnt_wd          = CW'(1);
          rsp_d.ref_count = CW'(1);
        end else begin
          rsp_d.status = rpa_pkg::ST_NO_MEM;
        end
      end
      rpa_pkg::FN_FREE: begin
        if (!addr_ok_q) begin
          rsp_d.status = rpa_pkg::ST_BAD_ADDR;
        end else if (cnt_rd_q == '0) begin
          rsp_d.status = rpa_pkg::ST_DOUBLE_FREE;
        end else begin
          cnt_we          = 1'b1;
          cnt_wd          = cnt_dec;
          rsp_d.ref_count = cnt_dec;
          if ((cnt_dec == '0) && (fill_q < CNT_W'(MAX_PAGES))) begin
            stk_we = 1'b1;
            fill_d = fill_q + CNT_W'(1);
          end
        end
      end
      rpa_pkg::FN_ADDREF: begin
        if (!addr_ok_q) begin
          rsp_d.status = rpa_pkg::ST_BAD_ADDR;
        end else if (cnt_rd_q == rpa_pkg::COUNT_MAX) begin
          rsp_d.status    = rpa_pkg::ST_OVERFLOW;
          rsp_d.ref_count = rpa_pkg::COUNT_MAX;
        end else begin
          cnt_we          = 1'b1;
          cnt_wd          = cnt_rd_q + CW'(1);
          rsp_d.ref_count = cnt_rd_q + CW'(1);
        end
      end
      rpa_pkg::FN_READ: begin
        if (!addr_ok_q) begin
          rsp_d.status = rpa_pkg::ST_BAD_ADDR;
        end else begin
          rsp_d.ref_count = cnt_rd_q;
        end
      end
      default: begin
        rsp_d.status = rpa_pkg::ST_OK;
      end
    endcase
    if ((func_q == rpa_pkg::FN_ALLOC) && (rsp_d.status == rpa_pkg::ST_OK)) begin
      rsp_d.granted_address = rpa_pkg::ADDR_W'(gsum) << PAGE_SHIFT;
    end
    if (!cmd_i.exec_en) begin
      cnt_we  = 1'b0;
      stk_we  = 1'b0;
      fill_d  = fill_q;
      fresh_d = fresh_q;
    end
  end

  assign gsum = G_W'(base_q) + G_W'(ex_idx);

  // During the clearing pass the count memory is written with zero.
  assign cnt_wa = cmd_i.clr_en ? clr_q : ex_idx;

  always_ff @(posedge clk_i) begin
    if (cnt_we || cmd_i.clr_en) begin
      cnt_mem[cnt_wa] <= cmd_i.clr_en ? '0 : cnt_wd;
    end
    if (cmd_i.look_en) begin
      cnt_rd_q <= cnt_mem[addr_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[fill_q[IDX_W-1:0]] <= idx_q;
    end
    if (cmd_i.look_en) begin
      stk_rd_q <= stk_mem[fill_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      fresh_q <= '0;
      clr_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      fresh_q <= fresh_d;
      if (cmd_i.clr_en) clr_q <= clr_q + IDX_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.exec_en) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_en) rsp_q <= rsp_d;
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign rsp_data_o      = rsp_q;
  assign stat_o.clr_last = (clr_q == IDX_W'(MAX_PAGES - 1));
  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;

endmodule

`default_nettype wire

### hdl/rpa_checker.sv
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level checks of the allocator result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpa_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          rsp_valid_i,
  input wire logic          rsp_ready_i,
  input wire rpa_pkg::rsp_t rsp_data_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result word changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status == rpa_pkg::ST_BAD_ADDR ||
                    rsp_data_i.status == rpa_pkg::ST_NO_MEM)
    |-> rsp_data_i.ref_count == '0 && rsp_data_i.granted_address == '0)
    else $error("failed request reports a count or an address");

  a_grant_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.granted_address != '0
    |-> rsp_data_i.status == rpa_pkg::ST_OK && rsp_data_i.ref_count == 8'd1)
    else $error("granted page without a count of one");

  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status == rpa_pkg::ST_DOUBLE_FREE ||
                    rsp_data_i.status == rpa_pkg::ST_OVERFLOW)
    |-> (rsp_data_i.status == rpa_pkg::ST_DOUBLE_FREE && rsp_data_i.ref_count == '0) ||
        (rsp_data_i.status == rpa_pkg::ST_OVERFLOW &&
         rsp_data_i.ref_count == rpa_pkg::COUNT_MAX))
    else $error("count does not match the error status");

endmodule

bind refcounted_page_allocator_unit rpa_checker u_rpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

`default_nettype wire

### sim/tb_refcounted_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_page_allocator_unit
// Self-checking bench for the reference-counted page allocator. A predictor
// keeps its own copy of the freed-page stack, the fresh-page cursor and the
// per-page counts, and works out the result of every accepted request word.
// Directed words cover the corner cases, then random traffic runs under
// several region settings, with random stalls on both channels in all but the last.
// ----------------------------------------------------------------------------
module tb_refcounted_page_allocator_unit;
  import rpa_pkg::*;

  localparam int unsigned N_PAGES  = MAX_PAGES_DEF;
  localparam int unsigned PG_SHIFT = PAGE_SHIFT_DEF;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [BASE_W-1:0]    cfg_wdata_i = '0;

  rpa_stream_if #(.payload_t(req_t)) req_if ();
  rpa_stream_if #(.payload_t(rsp_t)) rsp_if ();

  refcounted_page_allocator_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  logic [BASE_W-1:0]  rgn_base  = '0;
  logic [PAGES_W-1:0] rgn_pages = '0;
  int unsigned        free_lifo [N_PAGES];
  int unsigned        lifo_fill  = 0;
  int unsigned        fresh_used = 0;
  logic [COUNT_W-1:0] page_refs [N_PAGES];
  int unsigned        granted_idx_q [$];

  req_t req_todo_q [$];
  rsp_t rsp_due_q [$];
  rsp_t rsp_got;
  rsp_t rsp_want;

  bit          req_taken = 1'b0;
  bit          calm      = 1'b0;
  int unsigned req_gap   = 0;
  int unsigned rsp_gap   = 0;
  int unsigned n_err     = 0;
  int unsigned n_req     = 0;
  int unsigned n_rsp     = 0;
  int unsigned status_seen [5] = '{default: 0};

  function automatic int unsigned live_pages();
    return (rgn_pages > N_PAGES) ? N_PAGES : 32'(rgn_pages);
  endfunction

  function automatic void predict_page_op(input req_t r);
    rsp_t        res;
    int unsigned live;
    int unsigned idx;
    logic [63:0] pn;
    logic [63:0] byte_addr;
    bit          got;
    res.status          = ST_OK;
    res.granted_address = '0;
    res.ref_count       = '0;
    live = live_pages();
    idx  = 0;
    got  = 1'b0;
    if (r.func == FN_ALLOC) begin
      if (lifo_fill > 0) begin
        lifo_fill--;
        idx = free_lifo[lifo_fill];
        got = (idx < N_PAGES);
      end else if (fresh_used < live) begin
        idx = live - 1 - fresh_used;
        fresh_used++;
        got = 1'b1;
      end
      if (got) begin
        page_refs[idx] = COUNT_W'(1);
        res.ref_count = COUNT_W'(1);
        byte_addr = (64'(rgn_base) + 64'(idx)) << PG_SHIFT;
        res.granted_address = byte_addr[ADDR_W-1:0];
        granted_idx_q.push_back(idx);
        if (granted_idx_q.size() > 32) void'(granted_idx_q.pop_front());
      end else begin
        res.status = ST_NO_MEM;
      end
    end else begin
      pn = 64'(r.page_address) >> PG_SHIFT;
      if (r.page_address[PG_SHIFT-1:0] != '0 || pn < 64'(rgn_base) ||
          pn - 64'(rgn_base) >= 64'(live)) begin
        res.status = ST_BAD_ADDR;
      end else begin
        idx = 32'(pn - 64'(rgn_base));
        case (r.func)
          FN_FREE: begin
            if (page_refs[idx] == '0) begin
              res.status = ST_DOUBLE_FREE;
            end else begin
              page_refs[idx] = page_refs[idx] - 1'b1;
              res.ref_count = page_refs[idx];
              if (page_refs[idx] == '0 && lifo_fill < N_PAGES) begin
                free_lifo[lifo_fill] = idx;
                lifo_fill++;
              end
            end
          end
          FN_ADDREF: begin
            if (page_refs[idx] >= COUNT_MAX) begin
              res.status    = ST_OVERFLOW;
              res.ref_count = COUNT_MAX;
            end else begin
              page_refs[idx] = page_refs[idx] + 1'b1;
              res.ref_count = page_refs[idx];
            end
          end
          default: begin
            res.ref_count = page_refs[idx];
          end
        endcase
      end
    end
    rsp_due_q.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_err++;
  endtask

  // Monitor: configuration writes, accepted requests and returned results.
  always @(posedge clk_i) begin
    req_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BASE) begin
          rgn_base = cfg_wdata_i;
        end else begin
          rgn_pages = cfg_wdata_i[PAGES_W-1:0];
        end
      end
      if (req_if.valid && req_if.ready) begin
        predict_page_op(req_if.data);
        n_req++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_got = rsp_if.data;
        if (rsp_due_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding",
                          rsp_got.granted_address, '0);
        end else begin
          rsp_want = rsp_due_q.pop_front();
          n_rsp++;
          if (int'(rsp_want.status) < 5) status_seen[int'(rsp_want.status)]++;
          if (rsp_got.status !== rsp_want.status) begin
            report_mismatch("status", 32'(rsp_got.status), 32'(rsp_want.status));
          end
          if (rsp_got.granted_address !== rsp_want.granted_address) begin
            report_mismatch("granted_address", rsp_got.granted_address,
                            rsp_want.granted_address);
          end
          if (rsp_got.ref_count !== rsp_want.ref_count) begin
            report_mismatch("ref_count", 32'(rsp_got.ref_count), 32'(rsp_want.ref_count));
          end
        end
      end
    end
  end

  // Driver: request words from the pending queue, random stall bursts.
  always @(negedge clk_i) begin
    if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rsp_gap = $urandom_range(0, 5);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
    if (!req_if.valid || req_taken) begin
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (req_todo_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        req_gap = $urandom_range(0, 5);
        req_if.valid <= 1'b0;
      end else if (req_todo_q.size() != 0) begin
        req_if.valid <= 1'b1;
        req_if.data  <= req_todo_q.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  task automatic push_req(input func_e f, input logic [31:0] a);
    req_t r;
    while (req_todo_q.size() > 3) @(negedge clk_i);
    r.func         = f;
    r.page_address = a;
    req_todo_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (req_todo_q.size() != 0 || req_if.valid || rsp_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [BASE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= which;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_region(input logic [BASE_W-1:0] base, input logic [PAGES_W-1:0] pages);
    wait_idle();
    write_reg(CFG_BASE, base);
    write_reg(CFG_PAGES, BASE_W'(pages));
  endtask

  function automatic logic [31:0] page_addr(input int unsigned idx);
    logic [63:0] a;
    a = (64'(rgn_base) + 64'(idx)) << PG_SHIFT;
    return a[31:0];
  endfunction

  // Mostly pages that were recently granted, some anywhere in the region or just
  // past its end, some misaligned and some pure noise.
  function automatic logic [31:0] pick_addr();
    int unsigned roll;
    int unsigned idx;
    logic [31:0] a;
    roll = $urandom_range(0, 19);
    if (granted_idx_q.size() != 0 && roll < 13) begin
      idx = granted_idx_q[$urandom_range(0, granted_idx_q.size() - 1)];
    end else begin
      idx = $urandom_range(0, live_pages() + 1);
    end
    if (roll >= 17) return $urandom;
    a = page_addr(idx);
    if (roll == 16) a[PG_SHIFT-1:0] = PG_SHIFT'($urandom_range(1, (1 << PG_SHIFT) - 1));
    return a;
  endfunction

  task automatic random_ops(input int unsigned n);
    int unsigned roll;
    func_e       f;
    repeat (n) begin
      roll = $urandom_range(0, 9);
      f = (roll < 3) ? FN_ALLOC : (roll < 6) ? FN_FREE : (roll < 8) ? FN_ADDREF : FN_READ;
      push_req(f, (f == FN_ALLOC) ? $urandom : pick_addr());
    end
  endtask

  // Drives one page up to the count limit and two steps past it.
  task automatic pump_refcount();
    logic [31:0] a;
    push_req(FN_ALLOC, '0);
    wait_idle();
    if (granted_idx_q.size() != 0) begin
      a = page_addr(granted_idx_q[$]);
      repeat (256) push_req(FN_ADDREF, a);
      push_req(FN_READ, a);
      repeat (3) push_req(FN_FREE, a);
    end
  endtask

  initial begin
    foreach (page_refs[i]) page_refs[i] = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty region straight out of reset.
    push_req(FN_ALLOC, 32'hFFFF_FFFF);
    push_req(FN_READ, 32'h0000_0000);

    // Four pages at address zero: exhaust, count up and down, reuse.
    set_region(20'h0, 16'd4);
    repeat (5) push_req(FN_ALLOC, '0);
    push_req(FN_READ, 32'h0000_3000);
    push_req(FN_ADDREF, 32'h0000_3000);
    repeat (3) push_req(FN_FREE, 32'h0000_3000);
    push_req(FN_FREE, 32'h0000_3001);
    push_req(FN_READ, 32'h0000_4000);
    push_req(FN_ALLOC, '0);
    push_req(FN_READ, 32'hFFFF_FFFF);

    // Top base with an oversized page count: granted addresses wrap.
    set_region(20'hFFFFF, 16'hFFFF);
    push_req(FN_ALLOC, '0);
    push_req(FN_READ, 32'hFFFF_F000);
    push_req(FN_ADDREF, 32'hFFFF_F000);
    push_req(FN_FREE, 32'hFFFF_F000);
    push_req(FN_ALLOC, 32'h5555_5555);

    set_region(BASE_W'($urandom), 16'd16);
    random_ops(180);
    set_region(20'h0, 16'd64);
    pump_refcount();
    random_ops(180);
    set_region(BASE_W'($urandom_range(0, 'hF0000)), 16'hFFFF);
    random_ops(220);
    set_region(20'hFFFFF, 16'd200);
    random_ops(150);
    set_region(BASE_W'($urandom_range(0, 1000)), 16'd0);
    random_ops(40);
    set_region(BASE_W'($urandom), 16'd24);
    random_ops(180);
    set_region(20'h0, 16'd32768);
    random_ops(180);
    set_region(BASE_W'($urandom_range(0, 4096)), 16'd40);
    calm = 1'b1;
    random_ops(200);

    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("Summary: %0d request words and %0d result words checked under eleven",
             n_req, n_rsp);
    $display("region settings, %0d mismatches. Result mix: %0d ok, %0d bad address,",
             n_err, status_seen[0], status_seen[1]);
    $display("%0d out of memory, %0d double free, %0d overflow.",
             status_seen[2], status_seen[3], status_seen[4]);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d result words outstanding.", rsp_due_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
